// ===== rtl/lruc_pkg.sv =====
package lruc_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int EVC_W  = 5;

	localparam logic [1:0] REQ_GET   = 2'd0;
	localparam logic [1:0] REQ_PUT   = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic key;
		logic value;
		logic age;
	} store_we_t;

	typedef struct packed {
		logic key_eq;
		logic age_lt;
		logic age_ge;
	} cmp_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] value_out;
		logic              accepted;
		logic [EVC_W-1:0]  evicted_count;
	} result_t;

endpackage

// ===== rtl/lruc_entry_unit.sv =====
module lruc_entry_unit import lruc_pkg::*; #(
	parameter int AGE_W = 4
) (
	input  logic [KEY_W-1:0] key_a,
	input  logic [KEY_W-1:0] key_b,
	input  logic [AGE_W-1:0] age,
	input  logic [AGE_W-1:0] ref_age,
	input  logic [AGE_W-1:0] thr,
	output cmp_t             cmp,
	output logic [AGE_W-1:0] age_inc
);

	always_comb begin
		cmp.key_eq = (key_a == key_b);
		cmp.age_lt = (age < ref_age);
		cmp.age_ge = (age >= thr);
		age_inc    = age + AGE_W'(1);
	end

endmodule

// ===== rtl/lruc_store.sv =====
module lruc_store import lruc_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int AGE_W = 4,
	parameter int VAL_W = 32
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	input  store_we_t        we,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [KEY_W-1:0] key_wd,
	input  logic [VAL_W-1:0] val_wd,
	input  logic [AGE_W-1:0] age_wd,
	output logic [KEY_W-1:0] key_rd,
	output logic [VAL_W-1:0] val_rd,
	output logic [AGE_W-1:0] age_rd
);

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [AGE_W-1:0] age_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we.key) begin
			key_mem[wr_addr] <= key_wd;
		end
		if (we.value) begin
			val_mem[wr_addr] <= val_wd;
		end
		if (we.age) begin
			age_mem[wr_addr] <= age_wd;
		end
		if (rd_en) begin
			key_rd <= key_mem[rd_addr];
			val_rd <= val_mem[rd_addr];
			age_rd <= age_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/lruc_ctrl.sv =====
module lruc_ctrl import lruc_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int AGE_W = 4,
	parameter int VAL_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [KEY_W-1:0]  key,
	input  logic [DATA_W-1:0] value_in,
	input  logic [AGE_W-1:0]  cap_thr,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	output store_we_t         we,
	output logic [IDX_W-1:0]  wr_addr,
	output logic [KEY_W-1:0]  key_wd,
	output logic [VAL_W-1:0]  val_wd,
	output logic [AGE_W-1:0]  age_wd,
	input  logic [KEY_W-1:0]  key_rd,
	input  logic [VAL_W-1:0]  val_rd,
	input  logic [AGE_W-1:0]  age_rd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_VREAD  = 4'd2;
	localparam logic [3:0] S_AGE    = 4'd3;
	localparam logic [3:0] S_EVICT  = 4'd4;
	localparam logic [3:0] S_INSERT = 4'd5;
	localparam logic [3:0] S_DONE   = 4'd6;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	logic [3:0]       state_q;
	logic [DEPTH-1:0] valid_q;
	logic [1:0]       req_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             hit_q;
	logic             acc_q;
	logic [EVC_W-1:0] ev_q;
	logic [IDX_W-1:0] slot_q;
	logic [AGE_W-1:0] slot_age_q;
	logic [IDX_W-1:0] free_q;
	logic             free_found_q;
	logic [IDX_W-1:0] idx_q;
	logic             iss_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             sweeping;
	logic             s1_last;
	logic             ent_vld;
	logic             scan_hit;
	logic             restart;
	cmp_t             cmp;
	logic [AGE_W-1:0] age_inc;

	lruc_entry_unit #(
		.AGE_W(AGE_W)
	) u_unit (
		.key_a  (key_rd),
		.key_b  (key_q),
		.age    (age_rd),
		.ref_age(slot_age_q),
		.thr    (cap_thr),
		.cmp    (cmp),
		.age_inc(age_inc)
	);

	assign sweeping = (state_q == S_SCAN) || (state_q == S_AGE) || (state_q == S_EVICT);
	assign s1_last  = vld_s1 && (idx_s1 == LAST_IDX);
	assign ent_vld  = valid_q[idx_s1];
	assign scan_hit = (state_q == S_SCAN) && vld_s1 && ent_vld && cmp.key_eq;
	// start a fresh sweep from entry zero
	assign restart  = ((state_q == S_IDLE) && in_valid) || scan_hit ||
	                  ((state_q == S_SCAN) && s1_last);
	assign in_ready = (state_q == S_IDLE);
	assign rd_en    = (state_q == S_VREAD) || (iss_q && sweeping);
	assign rd_addr  = (state_q == S_VREAD) ? slot_q : idx_q;

	always_comb begin
		we      = '0;
		wr_addr = idx_s1;
		key_wd  = key_q;
		val_wd  = val_q;
		age_wd  = age_inc;
		unique case (state_q)
			S_SCAN: begin
				if (vld_s1 && ent_vld && cmp.key_eq && req_q == REQ_PUT) begin
					we.value = 1'b1;
				end
			end
			S_AGE: begin
				// move the hit entry to the front, age those that were ahead of it
				if (vld_s1 && ent_vld) begin
					if (idx_s1 == slot_q) begin
						we.age = 1'b1;
						age_wd = '0;
					end else if (cmp.age_lt) begin
						we.age = 1'b1;
					end
				end
			end
			S_EVICT: begin
				if (vld_s1 && ent_vld && !cmp.age_ge) begin
					we.age = 1'b1;
				end
			end
			S_INSERT: begin
				wr_addr = free_q;
				we      = '1;
				age_wd  = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.hit           = hit_q;
		res.value_out     = (req_q == REQ_GET && hit_q) ? DATA_W'(val_rd) : '0;
		res.accepted      = acc_q;
		res.evicted_count = ev_q;
		res_valid         = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			iss_q        <= 1'b0;
			vld_s1       <= 1'b0;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			acc_q        <= 1'b0;
			ev_q         <= '0;
			req_q        <= REQ_GET;
		end else begin
			// advance the read sweep; the stage-1 copy lines up with read data
			vld_s1 <= !restart && iss_q && sweeping;
			idx_s1 <= idx_q;
			if (restart) begin
				idx_q <= '0;
				iss_q <= 1'b1;
			end else if (iss_q && sweeping) begin
				if (idx_q == LAST_IDX) begin
					iss_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q        <= req_type;
						key_q        <= key;
						val_q        <= value_in[VAL_W-1:0];
						hit_q        <= 1'b0;
						ev_q         <= '0;
						free_found_q <= 1'b0;
						if (req_type == REQ_GET || (req_type == REQ_PUT && !key[KEY_W-1])) begin
							acc_q   <= 1'b1;
							state_q <= S_SCAN;
						end else if (req_type == REQ_FLUSH) begin
							acc_q   <= 1'b1;
							valid_q <= '0;
							state_q <= S_DONE;
						end else begin
							acc_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						hit_q      <= 1'b1;
						slot_q     <= idx_s1;
						slot_age_q <= age_rd;
						state_q    <= (req_q == REQ_GET) ? S_VREAD : S_AGE;
					end else if (s1_last) begin
						state_q <= (req_q == REQ_GET) ? S_DONE : S_EVICT;
					end
				end
				S_VREAD: begin
					state_q <= S_DONE;
				end
				S_AGE: begin
					if (s1_last) begin
						state_q <= S_DONE;
					end
				end
				S_EVICT: begin
					if (vld_s1) begin
						// drop every entry ranked at or past the capacity limit
						if (ent_vld && cmp.age_ge) begin
							valid_q[idx_s1] <= 1'b0;
							ev_q            <= ev_q + EVC_W'(1);
						end
						if ((!ent_vld || cmp.age_ge) && !free_found_q) begin
							free_q       <= idx_s1;
							free_found_q <= 1'b1;
						end
					end
					if (s1_last) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					valid_q[free_q] <= 1'b1;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   req_type, key, value_in
// out       output     out_valid / out_ready hit, value_out, accepted, evicted_count
// cfg       input      cfg_valid / cfg_ready cfg_data (capacity)
//
// One item at a time. Each lookup or update sweeps the key, value and age memories
// through their single read port, one entry per cycle. A get scans and, on a hit,
// reads the value; a put scans, then on a hit sweeps again to update the ages, else
// sweeps to evict and then inserts. Flush and rejected requests skip the sweep.
// Reset clears valid bits and returns capacity to 16; no clearing pass is needed.
// A finished item waits in the output register while the next one is accepted.
module lru_key_value_cache import lruc_pkg::*; #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [KEY_W-1:0]  key,
	input  logic [DATA_W-1:0] value_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [DATA_W-1:0] value_out,
	output logic              accepted,
	output logic [EVC_W-1:0]  evicted_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VAL_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;
	logic [AGE_W-1:0] cap_thr;
	logic             out_valid_q;
	result_t          out_res_q;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	store_we_t        we;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] key_wd;
	logic [VAL_W-1:0] val_wd;
	logic [AGE_W-1:0] age_wd;
	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;
	logic [AGE_W-1:0] age_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// zero acts as one, and anything past the storage saturates
	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > CAPACITY) begin
			cap_eff = CNT_W'(CAPACITY);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
		cap_thr = AGE_W'(cap_eff - CNT_W'(1));
	end

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_res_q.hit;
	assign value_out     = out_res_q.value_out;
	assign accepted      = out_res_q.accepted;
	assign evicted_count = out_res_q.evicted_count;

	lruc_store #(
		.DEPTH(CAPACITY),
		.IDX_W(IDX_W),
		.AGE_W(AGE_W),
		.VAL_W(VAL_W)
	) u_store (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.we     (we),
		.wr_addr(wr_addr),
		.key_wd (key_wd),
		.val_wd (val_wd),
		.age_wd (age_wd),
		.key_rd (key_rd),
		.val_rd (val_rd),
		.age_rd (age_rd)
	);

	lruc_ctrl #(
		.DEPTH(CAPACITY),
		.IDX_W(IDX_W),
		.AGE_W(AGE_W),
		.VAL_W(VAL_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.key      (key),
		.value_in (value_in),
		.cap_thr  (cap_thr),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.we       (we),
		.wr_addr  (wr_addr),
		.key_wd   (key_wd),
		.val_wd   (val_wd),
		.age_wd   (age_wd),
		.key_rd   (key_rd),
		.val_rd   (val_rd),
		.age_rd   (age_rd)
	);

endmodule

// ===== rtl/lruc_checker.sv =====
module lruc_checker import lruc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        req_type,
	input logic [KEY_W-1:0]  key,
	input logic [DATA_W-1:0] value_in,
	input logic              out_valid,
	input logic              out_ready,
	input logic              hit,
	input logic [DATA_W-1:0] value_out,
	input logic              accepted,
	input logic [EVC_W-1:0]  evicted_count,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [CAP_W-1:0]  cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(hit))
		else $error("out item changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> !hit && value_out == '0 && evicted_count == '0)
		else $error("rejected item carries nonzero fields");

	a_hit_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> accepted && evicted_count == '0)
		else $error("hit on an item that was not carried out");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> value_out == '0)
		else $error("value returned without a hit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("next item taken before the current one finished");

endmodule

bind lru_key_value_cache lruc_checker u_lruc_checker (.*);
